/* src/yturn_pkg.sv */
// Package for the yaw turn controller: register map, request and result codes,
// configuration and queue word types, divide-by-1000 reciprocal constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package yturn_pkg;

   // request kinds
   localparam logic [1:0] REQ_START  = 2'd0;
   localparam logic [1:0] REQ_SAMPLE = 2'd1;
   localparam logic [1:0] REQ_ABORT  = 2'd2;

   // drive codes
   localparam logic [1:0] DRIVE_BRAKE = 2'd0;
   localparam logic [1:0] DRIVE_RIGHT = 2'd1;
   localparam logic [1:0] DRIVE_LEFT  = 2'd2;

   // phase codes as reported on the result channel
   localparam logic [1:0] PHASE_CODE_IDLE   = 2'd0;
   localparam logic [1:0] PHASE_CODE_TURN   = 2'd1;
   localparam logic [1:0] PHASE_CODE_SETTLE = 2'd2;

   // outcome codes
   localparam logic [1:0] OUTC_SUCCESS = 2'd0;
   localparam logic [1:0] OUTC_TIMEOUT = 2'd1;
   localparam logic [1:0] OUTC_ABORT   = 2'd2;

   // register indexes
   localparam logic [2:0] REG_FAST_PWM    = 3'd0;
   localparam logic [2:0] REG_SLOW_PWM    = 3'd1;
   localparam logic [2:0] REG_SLOW_ZONE   = 3'd2;
   localparam logic [2:0] REG_TOLERANCE   = 3'd3;
   localparam logic [2:0] REG_BRAKE_MS    = 3'd4;
   localparam logic [2:0] REG_MAX_LEAD    = 3'd5;
   localparam logic [2:0] REG_TIMEOUT     = 3'd6;
   localparam logic [2:0] REG_STABLE_RATE = 3'd7;

   // |rate| * brake_ms and its quotient by 1000
   localparam int MAG_W    = 19;
   localparam int PROD_W   = 29;
   localparam int QUOT_W   = 20;
   localparam int DIV_SHIFT = 38;
   // ceil(2^38 / 1000); exact floor for every product below 2^29
   localparam logic [PROD_W-1:0] RECIP_1000 = 29'd274877907;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_TURN   = 3'b010,
      PH_SETTLE = 3'b100
   } phase_type;

   typedef struct packed {
      logic [6:0]  fast_pwm;
      logic [6:0]  slow_pwm;
      logic [15:0] slow_zone;
      logic [15:0] angle_tolerance;
      logic [9:0]  brake_time_ms;
      logic [15:0] max_lead;
      logic [15:0] turn_timeout;
      logic [17:0] stable_rate;
   } cfg_type;

   // classified word handed from the front to the back
   typedef struct packed {
      logic [1:0]         kind;
      logic signed [17:0] aim_yaw;
      logic signed [17:0] yaw;
      logic [15:0]        lead;
      logic               hit;
      logic               right;
      logic               still;
   } item_type;

endpackage

`default_nettype wire

/* src/yturn_ifs.sv */
// Handshake channel interfaces for the yaw turn controller: request word in,
// result word out. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface yturn_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic signed [17:0] aim_yaw;
   logic signed [17:0] yaw;
   logic signed [18:0] gyro_rate;

   modport source (output valid, req_type, aim_yaw, yaw, gyro_rate, input ready);
   modport sink   (input valid, req_type, aim_yaw, yaw, gyro_rate, output ready);
endinterface

interface yturn_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] drive;
   logic [6:0] pwm_duty;
   logic [1:0] phase;
   logic       done_res;
   logic [1:0] outcome;

   modport source (output valid, drive, pwm_duty, phase, done_res, outcome, input ready);
   modport sink   (input valid, drive, pwm_duty, phase, done_res, outcome, output ready);
endinterface

`default_nettype wire

/* src/yturn_front.sv */
// Front end: accepts request words and classifies them in three stages
// (magnitudes and compares, rate times brake time, divide by 1000 and clamp).
// Depends on yturn_pkg and yturn_req_if.
`timescale 1ns / 1ps
`default_nettype none

module yturn_front (
   input  logic              clock,
   input  logic              reset,
   yturn_req_if.sink         req_chan,
   input  yturn_pkg::cfg_type cfg,
   output logic              q_valid,
   input  logic              q_ready,
   output yturn_pkg::item_type q_item
);
   import yturn_pkg::*;

   logic en1, en2, en3;
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;

   logic signed [18:0] err;
   logic [MAG_W-1:0]   err_mag;
   logic [MAG_W-1:0]   rate_mag;
   logic [MAG_W-1:0]   rate_u;
   logic [18:0]        err_u;

   item_type           s1_ff, s1_in, s2_ff, s3_ff;
   logic [MAG_W-1:0]   mag1_ff;
   logic [PROD_W-1:0]  prod2_ff, prod2_in;
   logic [QUOT_W-1:0]  quot3_ff, quot3_in;
   logic [2*PROD_W-1:0] scaled;

   // elastic stages: a stage loads when it is empty or its content moves on
   assign en3 = !v3_ff || q_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_chan.ready = en1;

   assign v1_in = en1 ? req_chan.valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;

   always_comb begin
      err      = 19'(req_chan.aim_yaw) - 19'(req_chan.yaw);
      err_u    = err;
      err_mag  = err[18] ? (~err_u + 19'd1) : err_u;
      rate_u   = req_chan.gyro_rate;
      rate_mag = rate_u[18] ? (~rate_u + 19'd1) : rate_u;
      s1_in            = '0;
      s1_in.kind       = req_chan.req_type;
      s1_in.aim_yaw    = req_chan.aim_yaw;
      s1_in.yaw        = req_chan.yaw;
      s1_in.hit        = err_mag <= MAG_W'(cfg.angle_tolerance);
      s1_in.right      = req_chan.aim_yaw > req_chan.yaw;
      s1_in.still      = rate_mag <= MAG_W'(cfg.stable_rate);
   end

   assign prod2_in = PROD_W'(mag1_ff) * PROD_W'(cfg.brake_time_ms);
   assign scaled   = (2*PROD_W)'(prod2_ff) * (2*PROD_W)'(RECIP_1000);
   assign quot3_in = scaled[DIV_SHIFT +: QUOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff   <= s1_in;
         mag1_ff <= rate_mag;
      end
      if (en2) begin
         s2_ff    <= s1_ff;
         prod2_ff <= prod2_in;
      end
      if (en3) begin
         s3_ff    <= s2_ff;
         quot3_ff <= quot3_in;
      end
   end

   // clamp: lower bound first, so a tolerance above max_lead wins for small leads
   always_comb begin
      q_item = s3_ff;
      if (quot3_ff < QUOT_W'(cfg.angle_tolerance)) begin
         q_item.lead = cfg.angle_tolerance;
      end else if (quot3_ff > QUOT_W'(cfg.max_lead)) begin
         q_item.lead = cfg.max_lead;
      end else begin
         q_item.lead = quot3_ff[15:0];
      end
   end

   assign q_valid = v3_ff;

endmodule

`default_nettype wire

/* src/yturn_queue.sv */
// Short word queue between the front and back ends so each side stalls alone.
// Depends on yturn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yturn_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  yturn_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output yturn_pkg::item_type out_item
);
   import yturn_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            push, pop;

   assign in_ready  = cnt_ff != CW'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

/* src/yturn_back.sv */
// Back end: turn sequencer state machine; applies one classified word per cycle
// unless the held result word is not taken, and holds it until taken. Needs yturn_pkg, yturn_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module yturn_back #(
   parameter int SETTLE_SAMPLES = 100,
   parameter int STABLE_RUN     = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  yturn_pkg::cfg_type  cfg,
   input  logic               q_valid,
   output logic               q_ready,
   input  yturn_pkg::item_type q_item,
   yturn_rsp_if.source        rsp_chan
);
   import yturn_pkg::*;

   localparam int SW = $clog2(SETTLE_SAMPLES + 1);
   localparam int QW = $clog2(STABLE_RUN + 1);

   phase_type          phase_ff, phase_in;
   logic signed [17:0] goal_ff, goal_in;
   logic               right_ff, right_in;
   logic               slow_ff, slow_in;
   logic [15:0]        ts_ff, ts_in, ts_next;
   logic [SW-1:0]      ss_ff, ss_in, ss_next;
   logic [QW-1:0]      qr_ff, qr_in;
   logic               tmo_ff, tmo_in;
   logic [1:0]         drive_ff, drive_in;
   logic [6:0]         pwm_ff, pwm_in;
   logic               done_ff, done_in;
   logic [1:0]         outc_ff, outc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               pop;
   logic signed [18:0] rem;
   logic signed [19:0] rem_w;

   assign q_ready = !rsp_valid_ff || rsp_chan.ready;
   assign pop     = q_valid && q_ready;

   assign rem     = right_ff ? (19'(goal_ff) - 19'(q_item.yaw))
                             : (19'(q_item.yaw) - 19'(goal_ff));
   assign rem_w   = 20'(rem);
   assign ts_next = (ts_ff == 16'hFFFF) ? ts_ff : ts_ff + 16'd1;
   assign ss_next = ss_ff + SW'(1);

   always_comb begin
      phase_in = phase_ff;
      goal_in  = goal_ff;
      right_in = right_ff;
      slow_in  = slow_ff;
      ts_in    = ts_ff;
      ss_in    = ss_ff;
      qr_in    = qr_ff;
      tmo_in   = tmo_ff;
      drive_in = drive_ff;
      pwm_in   = pwm_ff;
      done_in  = done_ff;
      outc_in  = outc_ff;
      if (pop) begin
         done_in = 1'b0;
         outc_in = OUTC_SUCCESS;
         unique case (q_item.kind)
            REQ_START: begin
               goal_in = q_item.aim_yaw;
               tmo_in  = 1'b0;
               slow_in = 1'b0;
               ts_in   = '0;
               ss_in   = '0;
               qr_in   = '0;
               if (q_item.hit) begin
                  drive_in = DRIVE_BRAKE;
                  pwm_in   = '0;
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end else begin
                  right_in = q_item.right;
                  drive_in = q_item.right ? DRIVE_RIGHT : DRIVE_LEFT;
                  pwm_in   = cfg.fast_pwm;
                  phase_in = PH_TURN;
               end
            end
            REQ_SAMPLE: begin
               unique case (phase_ff)
                  PH_TURN: begin
                     ts_in = ts_next;
                     if (rem_w <= $signed(20'(q_item.lead))) begin
                        tmo_in   = 1'b0;
                        drive_in = DRIVE_BRAKE;
                        pwm_in   = '0;
                        phase_in = PH_SETTLE;
                        ss_in    = '0;
                        qr_in    = '0;
                     end else begin
                        if (!slow_ff && rem_w <= $signed(20'(cfg.slow_zone))) begin
                           slow_in = 1'b1;
                           pwm_in  = cfg.slow_pwm;
                        end
                        if (ts_next >= cfg.turn_timeout) begin
                           tmo_in   = 1'b1;
                           drive_in = DRIVE_BRAKE;
                           pwm_in   = '0;
                           phase_in = PH_SETTLE;
                           ss_in    = '0;
                           qr_in    = '0;
                        end
                     end
                  end
                  PH_SETTLE: begin
                     ss_in = ss_next;
                     if (ss_next >= SW'(SETTLE_SAMPLES)) begin
                        phase_in = PH_IDLE;
                        done_in  = 1'b1;
                        outc_in  = tmo_ff ? OUTC_TIMEOUT : OUTC_SUCCESS;
                     end else if (q_item.still) begin
                        qr_in = qr_ff + QW'(1);
                        if (qr_ff + QW'(1) >= QW'(STABLE_RUN)) begin
                           phase_in = PH_IDLE;
                           done_in  = 1'b1;
                           outc_in  = tmo_ff ? OUTC_TIMEOUT : OUTC_SUCCESS;
                        end
                     end else begin
                        qr_in = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            REQ_ABORT: begin
               unique case (phase_ff)
                  PH_TURN: begin
                     drive_in = DRIVE_BRAKE;
                     pwm_in   = '0;
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                     outc_in  = OUTC_ABORT;
                  end
                  PH_SETTLE: begin
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                     outc_in  = tmo_ff ? OUTC_TIMEOUT : OUTC_SUCCESS;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // hold the result word until taken; a new word may replace it the same cycle
   assign rsp_valid_in = pop ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         goal_ff      <= '0;
         right_ff     <= 1'b0;
         slow_ff      <= 1'b0;
         ts_ff        <= '0;
         ss_ff        <= '0;
         qr_ff        <= '0;
         tmo_ff       <= 1'b0;
         drive_ff     <= DRIVE_BRAKE;
         pwm_ff       <= '0;
         done_ff      <= 1'b0;
         outc_ff      <= OUTC_SUCCESS;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         goal_ff      <= goal_in;
         right_ff     <= right_in;
         slow_ff      <= slow_in;
         ts_ff        <= ts_in;
         ss_ff        <= ss_in;
         qr_ff        <= qr_in;
         tmo_ff       <= tmo_in;
         drive_ff     <= drive_in;
         pwm_ff       <= pwm_in;
         done_ff      <= done_in;
         outc_ff      <= outc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      unique case (phase_ff)
         PH_TURN:   rsp_chan.phase = PHASE_CODE_TURN;
         PH_SETTLE: rsp_chan.phase = PHASE_CODE_SETTLE;
         default:   rsp_chan.phase = PHASE_CODE_IDLE;
      endcase
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.drive    = drive_ff;
   assign rsp_chan.pwm_duty = pwm_ff;
   assign rsp_chan.done_res = done_ff;
   assign rsp_chan.outcome  = outc_ff;

endmodule

`default_nettype wire

/* src/yaw_turn_controller_unit.sv */
// Yaw turn controller top level: register file, front end, queue, back end.
// Usage: a turn begins with a start word (req_type 0) carrying target and
// current yaw; gyro sample words (req_type 1) step the turn and the settling,
// and an abort word (req_type 2) ends it. Each request word gives exactly one
// result word with drive, PWM compare, phase, done and outcome.
// Path: a word accepted on req_chan enters the first front stage
// (magnitudes), passes two more front stages (rate times brake time,
// reciprocal multiply for the divide by 1000) and one queue slot, and has its
// result in the back end's output register, which drives rsp_chan.
// Throughput is one word per cycle while rsp_chan does not stall; the reciprocal
// multiplier and the back end's state update set that figure.
// The user writes registers over the APB port only while the block is idle;
// the block does not enforce this. Byte address 4*index; read back the same way.
// Reset (synchronous, active high) loads the register defaults, empties the
// pipeline and queue, and leaves the state idle with the motors braked.
// When the receiver stalls, the result word holds; the two-word queue and the
// front stages keep accepting until full, then req_chan.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module yaw_turn_controller_unit #(
   parameter int SETTLE_SAMPLES = 100,
   parameter int STABLE_RUN     = 5
) (
   input  logic        clock,
   input  logic        reset,
   yturn_req_if.sink   req_chan,
   yturn_rsp_if.source rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import yturn_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     cfg_wr;
   logic     fq_valid, fq_ready, qb_valid, qb_ready;
   item_type fq_item, qb_item;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         unique case (paddr[4:2])
            REG_FAST_PWM:    cfg_in.fast_pwm        = pwdata[6:0];
            REG_SLOW_PWM:    cfg_in.slow_pwm        = pwdata[6:0];
            REG_SLOW_ZONE:   cfg_in.slow_zone       = pwdata[15:0];
            REG_TOLERANCE:   cfg_in.angle_tolerance = pwdata[15:0];
            REG_BRAKE_MS:    cfg_in.brake_time_ms   = pwdata[9:0];
            REG_MAX_LEAD:    cfg_in.max_lead        = pwdata[15:0];
            REG_TIMEOUT:     cfg_in.turn_timeout    = pwdata[15:0];
            REG_STABLE_RATE: cfg_in.stable_rate     = pwdata[17:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_pwm        <= 7'd40;
         cfg_ff.slow_pwm        <= 7'd20;
         cfg_ff.slow_zone       <= 16'd3000;
         cfg_ff.angle_tolerance <= 16'd100;
         cfg_ff.brake_time_ms   <= 10'd130;
         cfg_ff.max_lead        <= 16'd2200;
         cfg_ff.turn_timeout    <= 16'd800;
         cfg_ff.stable_rate     <= 18'd300;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_FAST_PWM:    prdata = 32'(cfg_ff.fast_pwm);
         REG_SLOW_PWM:    prdata = 32'(cfg_ff.slow_pwm);
         REG_SLOW_ZONE:   prdata = 32'(cfg_ff.slow_zone);
         REG_TOLERANCE:   prdata = 32'(cfg_ff.angle_tolerance);
         REG_BRAKE_MS:    prdata = 32'(cfg_ff.brake_time_ms);
         REG_MAX_LEAD:    prdata = 32'(cfg_ff.max_lead);
         REG_TIMEOUT:     prdata = 32'(cfg_ff.turn_timeout);
         REG_STABLE_RATE: prdata = 32'(cfg_ff.stable_rate);
         default:         prdata = '0;
      endcase
   end

   yturn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg_ff),
      .q_valid  (fq_valid),
      .q_ready  (fq_ready),
      .q_item   (fq_item)
   );

   yturn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_item   (fq_item),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_item  (qb_item)
   );

   yturn_back #(
      .SETTLE_SAMPLES (SETTLE_SAMPLES),
      .STABLE_RUN     (STABLE_RUN)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (qb_valid),
      .q_ready  (qb_ready),
      .q_item   (qb_item),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

/* bench/tb_yaw_turn_controller_unit.sv */
// Self-checking bench for yaw_turn_controller_unit: directed table, then turn
// sequences under several register settings. Each result word is checked against
// a typed table row or the in-bench model. Depends on yturn_pkg and the interfaces in yturn_ifs.
`timescale 1ns / 1ps

module tb_yaw_turn_controller_unit;
   import yturn_pkg::*;

   localparam int SETTLE_SAMPLES = 100;
   localparam int STABLE_RUN     = 5;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int WORDS_PER_SETTING = 90;
   localparam int NUM_SETTINGS   = 7;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [17:0] target;
      logic signed [17:0] yaw;
      logic signed [18:0] rate;
   } turn_word_type;

   typedef struct packed {
      logic [1:0] drive;
      logic [6:0] pwm;
      logic [1:0] phase;
      logic       done;
      logic [1:0] outcome;
   } turn_status_type;

   typedef struct packed {
      turn_word_type   word;
      logic            typed;
      turn_status_type want;
   } directed_row_type;

   localparam turn_status_type ALL_IDLE =
      '{DRIVE_BRAKE, 7'd0, PHASE_CODE_IDLE, 1'b0, OUTC_SUCCESS};
   localparam turn_status_type PREDICT = '0;

   // rows with typed expectations are read straight off the default registers
   localparam directed_row_type DIRECTED [24] = '{
      '{'{REQ_SAMPLE, 18'sd0, 18'sd0, 19'sd200000}, 1'b1, ALL_IDLE},
      '{'{REQ_ABORT, 18'sd0, 18'sd0, 19'sd0}, 1'b1, ALL_IDLE},
      '{'{REQ_UNUSED, -18'sd100000, -18'sd100000, -19'sd200000}, 1'b1, ALL_IDLE},
      '{'{REQ_START, 18'sd0, 18'sd100, 19'sd0}, 1'b1,
        '{DRIVE_BRAKE, 7'd0, PHASE_CODE_IDLE, 1'b1, OUTC_SUCCESS}},
      '{'{REQ_START, 18'sd0, -18'sd101, 19'sd0}, 1'b1,
        '{DRIVE_RIGHT, 7'd40, PHASE_CODE_TURN, 1'b0, OUTC_SUCCESS}},
      '{'{REQ_START, -18'sd100000, 18'sd100000, 19'sd0}, 1'b1,
        '{DRIVE_LEFT, 7'd40, PHASE_CODE_TURN, 1'b0, OUTC_SUCCESS}},
      '{'{REQ_SAMPLE, 18'sd0, 18'sd0, -19'sd200000}, 1'b0, PREDICT},
      '{'{REQ_SAMPLE, 18'sd0, -18'sd97000, 19'sd0}, 1'b0, PREDICT},
      '{'{REQ_SAMPLE, 18'sd0, -18'sd98000, 19'sd1000}, 1'b0, PREDICT},
      '{'{REQ_SAMPLE, 18'sd0, -18'sd99000, 19'sd200000}, 1'b0, PREDICT},
      '{'{REQ_SAMPLE, 18'sd0, 18'sd0, 19'sd250}, 1'b0, PREDICT},
      '{'{REQ_SAMPLE, 18'sd0, 18'sd0, -19'sd5000}, 1'b0, PREDICT},
      '{'{REQ_SAMPLE, 18'sd0, 18'sd0, 19'sd300}, 1'b0, PREDICT},
      '{'{REQ_SAMPLE, 18'sd0, 18'sd0, -19'sd300}, 1'b0, PREDICT},
      '{'{REQ_SAMPLE, 18'sd0, 18'sd0, 19'sd0}, 1'b0, PREDICT},
      '{'{REQ_SAMPLE, 18'sd0, 18'sd0, 19'sd1}, 1'b0, PREDICT},
      '{'{REQ_SAMPLE, 18'sd0, 18'sd0, 19'sd299}, 1'b0, PREDICT},
      '{'{REQ_START, 18'sd100000, 18'sd0, 19'sd0}, 1'b1,
        '{DRIVE_RIGHT, 7'd40, PHASE_CODE_TURN, 1'b0, OUTC_SUCCESS}},
      '{'{REQ_ABORT, 18'sd0, 18'sd0, 19'sd0}, 1'b1,
        '{DRIVE_BRAKE, 7'd0, PHASE_CODE_IDLE, 1'b1, OUTC_ABORT}},
      '{'{REQ_START, 18'sd5000, 18'sd0, 19'sd0}, 1'b0, PREDICT},
      '{'{REQ_SAMPLE, 18'sd0, 18'sd4950, 19'sd0}, 1'b0, PREDICT},
      '{'{REQ_ABORT, 18'sd0, 18'sd0, 19'sd0}, 1'b0, PREDICT},
      '{'{REQ_ABORT, 18'sd0, 18'sd0, 19'sd0}, 1'b1, ALL_IDLE},
      '{'{REQ_START, 18'sd100000, 18'sd100000, 19'sd0}, 1'b1,
        '{DRIVE_BRAKE, 7'd0, PHASE_CODE_IDLE, 1'b1, OUTC_SUCCESS}}
   };

   localparam string FIELD_NAMES [5] = '{"drive", "pwm_duty", "phase", "done_res",
                                          "outcome"};

   logic        clock = 1'b0;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        pready;

   yturn_req_if req_chan ();
   yturn_rsp_if rsp_chan ();

   yaw_turn_controller_unit #(
      .SETTLE_SAMPLES(SETTLE_SAMPLES),
      .STABLE_RUN(STABLE_RUN)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #10 clock = ~clock;

   // turn model state and register copy
   cfg_type    cfg;
   logic [1:0] st_phase;
   int         st_goal;
   bit         st_right, st_slow, st_timed_out;
   int         st_samples, st_settle, st_quiet;
   logic [1:0] st_drive;
   logic [6:0] st_pwm;

   turn_status_type expected_status [$];
   int  mismatches = 0;
   int  cycle_count = 0;
   int  tx_idle_pct = 0;
   int  rx_idle_pct = 0;
   bit  long_hold_req = 1'b0;
   int  n_words = 0, n_live = 0;
   int  n_success = 0, n_timeout = 0, n_abort = 0;

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int rand_signed(input int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   function automatic int clamp_yaw(input int v);
      return (v > 100000) ? 100000 : ((v < -100000) ? -100000 : v);
   endfunction

   function automatic turn_word_type make_word(input logic [1:0] kind, input int target,
                                               input int yaw, input int rate);
      turn_word_type w;
      w.kind   = kind;
      w.target = target[17:0];
      w.yaw    = yaw[17:0];
      w.rate   = rate[18:0];
      return w;
   endfunction

   function automatic void brake_and_settle();
      st_drive  = DRIVE_BRAKE;
      st_pwm    = 7'd0;
      st_phase  = PHASE_CODE_SETTLE;
      st_settle = 0;
      st_quiet  = 0;
   endfunction

   // advance the turn model by one request word and return its status word
   function automatic turn_status_type predict_turn(input turn_word_type w);
      int         err, rem, lead, rate_mag;
      logic       done;
      logic [1:0] outc;
      logic       fin;
      done = 1'b0;
      outc = OUTC_SUCCESS;
      fin  = 1'b0;
      rate_mag = magnitude(int'(w.rate));
      case (w.kind)
         REQ_START: begin
            err = int'(w.target) - int'(w.yaw);
            st_goal = int'(w.target);
            st_timed_out = 1'b0;
            st_slow = 1'b0;
            st_samples = 0;
            st_settle = 0;
            st_quiet = 0;
            if (magnitude(err) <= int'(cfg.angle_tolerance)) begin
               st_drive = DRIVE_BRAKE;
               st_pwm = 7'd0;
               st_phase = PHASE_CODE_IDLE;
               done = 1'b1;
            end else begin
               st_right = (int'(w.target) > int'(w.yaw));
               st_drive = st_right ? DRIVE_RIGHT : DRIVE_LEFT;
               st_pwm = cfg.fast_pwm;
               st_phase = PHASE_CODE_TURN;
            end
         end
         REQ_SAMPLE: begin
            if (st_phase == PHASE_CODE_TURN) begin
               rem = st_right ? st_goal - int'(w.yaw) : int'(w.yaw) - st_goal;
               lead = int'((longint'(rate_mag) * longint'(cfg.brake_time_ms)) / 1000);
               // lower clamp wins when tolerance exceeds the lead ceiling
               if (lead < int'(cfg.angle_tolerance))
                  lead = int'(cfg.angle_tolerance);
               else if (lead > int'(cfg.max_lead))
                  lead = int'(cfg.max_lead);
               if (st_samples < 65535)
                  st_samples++;
               if (rem <= lead) begin
                  st_timed_out = 1'b0;
                  brake_and_settle();
               end else begin
                  if (!st_slow && rem <= int'(cfg.slow_zone)) begin
                     st_slow = 1'b1;
                     st_pwm = cfg.slow_pwm;
                  end
                  if (st_samples >= int'(cfg.turn_timeout)) begin
                     st_timed_out = 1'b1;
                     brake_and_settle();
                  end
               end
            end else if (st_phase == PHASE_CODE_SETTLE) begin
               st_settle = (st_settle + 1) & 127;
               if (st_settle >= SETTLE_SAMPLES) begin
                  fin = 1'b1;
               end else if (rate_mag <= int'(cfg.stable_rate)) begin
                  st_quiet = (st_quiet + 1) & 7;
                  if (st_quiet >= STABLE_RUN)
                     fin = 1'b1;
               end else begin
                  st_quiet = 0;
               end
               if (fin) begin
                  st_phase = PHASE_CODE_IDLE;
                  done = 1'b1;
                  outc = st_timed_out ? OUTC_TIMEOUT : OUTC_SUCCESS;
               end
            end
         end
         REQ_ABORT: begin
            if (st_phase == PHASE_CODE_TURN) begin
               st_drive = DRIVE_BRAKE;
               st_pwm = 7'd0;
               st_phase = PHASE_CODE_IDLE;
               done = 1'b1;
               outc = OUTC_ABORT;
            end else if (st_phase == PHASE_CODE_SETTLE) begin
               st_phase = PHASE_CODE_IDLE;
               done = 1'b1;
               outc = st_timed_out ? OUTC_TIMEOUT : OUTC_SUCCESS;
            end
         end
         default: ;
      endcase
      return '{st_drive, st_pwm, st_phase, done, outc};
   endfunction

   // offer one word, hold it until accepted, then record its expected status
   task automatic send_word(input turn_word_type w, input bit typed = 1'b0,
                            input turn_status_type typed_want = '0);
      turn_status_type want;
      logic [1:0]      phase_before;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.req_type  <= w.kind;
      req_chan.aim_yaw   <= w.target;
      req_chan.yaw       <= w.yaw;
      req_chan.gyro_rate <= w.rate;
      do @(posedge clock); while (!req_chan.ready);
      phase_before = st_phase;
      want = predict_turn(w);
      expected_status.push_back(typed ? typed_want : want);
      n_words++;
      if (w.kind == REQ_START || phase_before != PHASE_CODE_IDLE)
         n_live++;
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_status.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (index)
         REG_FAST_PWM:    cfg.fast_pwm        = value[6:0];
         REG_SLOW_PWM:    cfg.slow_pwm        = value[6:0];
         REG_SLOW_ZONE:   cfg.slow_zone       = value[15:0];
         REG_TOLERANCE:   cfg.angle_tolerance = value[15:0];
         REG_BRAKE_MS:    cfg.brake_time_ms   = value[9:0];
         REG_MAX_LEAD:    cfg.max_lead        = value[15:0];
         REG_TIMEOUT:     cfg.turn_timeout    = value[15:0];
         REG_STABLE_RATE: cfg.stable_rate     = value[17:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input cfg_type c);
      write_reg(REG_FAST_PWM,    32'(c.fast_pwm));
      write_reg(REG_SLOW_PWM,    32'(c.slow_pwm));
      write_reg(REG_SLOW_ZONE,   32'(c.slow_zone));
      write_reg(REG_TOLERANCE,   32'(c.angle_tolerance));
      write_reg(REG_BRAKE_MS,    32'(c.brake_time_ms));
      write_reg(REG_MAX_LEAD,    32'(c.max_lead));
      write_reg(REG_TIMEOUT,     32'(c.turn_timeout));
      write_reg(REG_STABLE_RATE, 32'(c.stable_rate));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // one turn: start, a run of samples closing on the target, then settling;
   // some turns follow a stray word, get aborted, restarted, or settle on a noisy gyro
   task automatic run_turn_sequence();
      turn_word_type w;
      int  tgt, cur, steps, settle_len, k, rate;
      bit  noisy;
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(2))
            0: w.kind = REQ_SAMPLE;
            1: w.kind = REQ_ABORT;
            default: w.kind = REQ_UNUSED;
         endcase
         send_word(make_word(w.kind, rand_signed(100000), rand_signed(100000),
                             rand_signed(200000)));
      end
      tgt = rand_signed(100000);
      if ($urandom_range(4) == 0)
         cur = clamp_yaw(tgt + rand_signed(int'(cfg.angle_tolerance) + 50));
      else
         cur = rand_signed(100000);
      send_word(make_word(REQ_START, tgt, cur, rand_signed(200000)));
      steps = $urandom_range(1, 10);
      for (k = steps; k > 0; k--) begin
         if ($urandom_range(29) == 0) begin
            send_word(make_word(REQ_ABORT, rand_signed(100000), cur, rand_signed(200000)));
            return;
         end
         if ($urandom_range(39) == 0) begin
            tgt = rand_signed(100000);
            send_word(make_word(REQ_START, tgt, cur, rand_signed(200000)));
         end
         cur = clamp_yaw(cur + (tgt - cur) / k + rand_signed(300));
         rate = ($urandom_range(1) == 0) ? rand_signed(200000) : rand_signed(20000);
         send_word(make_word(REQ_SAMPLE, rand_signed(100000), cur, rate));
      end
      noisy = ($urandom_range(14) == 0);
      settle_len = noisy ? SETTLE_SAMPLES + 5 : $urandom_range(1, 9);
      for (k = 0; k < settle_len; k++) begin
         if (noisy || $urandom_range(3) == 0)
            rate = rand_signed(200000);
         else
            rate = rand_signed(int'(cfg.stable_rate));
         send_word(make_word(REQ_SAMPLE, rand_signed(100000), cur, rate));
      end
      if ($urandom_range(7) == 0)
         send_word(make_word(REQ_ABORT, rand_signed(100000), cur, rand_signed(200000)));
   endtask

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin : result_sink
      bit hold_taken;
      int hold_left;
      hold_taken = 1'b0;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_results
      turn_status_type want, got;
      logic [6:0] want_f [5];
      logic [6:0] got_f [5];
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.drive, rsp_chan.pwm_duty, rsp_chan.phase, rsp_chan.done_res,
                 rsp_chan.outcome};
         if (expected_status.size() == 0) begin
            $display("%0t: result word with nothing expected, got %p", $time, got);
            mismatches++;
         end else begin
            want = expected_status.pop_front();
            want_f = '{7'(want.drive), want.pwm, 7'(want.phase), 7'(want.done),
                       7'(want.outcome)};
            got_f  = '{7'(got.drive), got.pwm, 7'(got.phase), 7'(got.done),
                       7'(got.outcome)};
            foreach (got_f[i]) begin
               if (got_f[i] !== want_f[i]) begin
                  $display("%0t: %s expected %0d actual %0d", $time, FIELD_NAMES[i],
                           want_f[i], got_f[i]);
                  mismatches++;
               end
            end
            if (got.done === 1'b1) begin
               case (got.outcome)
                  OUTC_SUCCESS: n_success++;
                  OUTC_TIMEOUT: n_timeout++;
                  OUTC_ABORT:   n_abort++;
                  default: ;
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles, %0d results still due", $time,
                  CYCLE_LIMIT, expected_status.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      cfg_type next_cfg;
      int      ph, words_start;
      bit      paused;
      req_chan.valid     = 1'b0;
      req_chan.req_type  = REQ_START;
      req_chan.aim_yaw   = '0;
      req_chan.yaw       = '0;
      req_chan.gyro_rate = '0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      reset   = 1'b1;
      paused  = 1'b0;
      cfg = '{7'd40, 7'd20, 16'd3000, 16'd100, 10'd130, 16'd2200, 16'd800, 18'd300};
      st_phase = PHASE_CODE_IDLE;
      st_goal = 0;
      st_right = 1'b0;
      st_slow = 1'b0;
      st_timed_out = 1'b0;
      st_samples = 0;
      st_settle = 0;
      st_quiet = 0;
      st_drive = DRIVE_BRAKE;
      st_pwm = 7'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct = 6;
      rx_idle_pct = 59;
      foreach (DIRECTED[i])
         send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want);

      for (ph = 0; ph < NUM_SETTINGS; ph++) begin
         tx_idle_pct = (ph < 3) ? 6 : ((ph < 5) ? 59 : 0);
         rx_idle_pct = (ph < 3) ? 59 : ((ph < 5) ? 6 : 0);
         if (ph > 0) begin
            wait_drained();
            next_cfg.fast_pwm        = 7'($urandom_range(99));
            next_cfg.slow_pwm        = 7'($urandom_range(99));
            next_cfg.slow_zone       = 16'($urandom_range(36000));
            next_cfg.angle_tolerance = 16'($urandom_range(400));
            next_cfg.brake_time_ms   = 10'($urandom_range(1000));
            next_cfg.max_lead        = 16'($urandom_range(5000));
            next_cfg.turn_timeout    = 16'($urandom_range(1, 30));
            next_cfg.stable_rate     = 18'($urandom_range(20000));
            case (ph)
               1: next_cfg = '{7'd99, 7'd99, 16'd36000, 16'd36000, 10'd1000, 16'd36000,
                               16'd65535, 18'd200000};
               2: next_cfg = '{7'd0, 7'd0, 16'd0, 16'd0, 10'd0, 16'd0, 16'd1, 18'd0};
               3: begin
                  // tolerance above the lead ceiling, zero timeout
                  next_cfg.angle_tolerance = 16'd500;
                  next_cfg.max_lead        = 16'd200;
                  next_cfg.turn_timeout    = 16'd0;
               end
               default: ;
            endcase
            apply_setting(next_cfg);
         end
         // hold the receiver off while words keep coming
         if (ph == 1)
            long_hold_req = 1'b1;
         words_start = n_words;
         while (n_words - words_start < WORDS_PER_SETTING) begin
            run_turn_sequence();
            if (ph == 3 && !paused && n_words - words_start > WORDS_PER_SETTING / 2) begin
               wait_drained();
               paused = 1'b1;
            end
         end
      end
      wait_drained();

      $display("Sent %0d request words (%0d on live turns) under %0d register settings.",
               n_words, n_live, NUM_SETTINGS);
      $display("Turns reported done: %0d success, %0d timeout, %0d aborted.",
               n_success, n_timeout, n_abort);
      if (mismatches == 0 && expected_status.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
